@@ rtl/core/ssx_pkg.sv @@
package ssx_pkg;

    // Byte codes and offsets taken from the SMBIOS structure layout.
    localparam logic [7:0] SERIAL_TYPE    = 8'h01;
    localparam logic [7:0] SERIAL_MIN_LEN = 8'h08;
    localparam logic [7:0] SERIAL_OFFSET  = 8'h07;
    localparam logic [7:0] MIN_LEN        = 8'h04;
    localparam logic [7:0] MAX_COUNT      = 8'hFF;
    localparam logic [7:0] MAX_LEN_RESET  = 8'hFF;

    // Configuration register indexes.
    localparam logic REG_MAX_SERIAL_LENGTH = 1'b0;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_end;
        logic       found;
    } t_result;

    // Up to two results leave the parser for one input byte.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

@@ rtl/core/ssx_parser.sv @@
module ssx_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_data_byte,
    input  logic             i_last_of_table,
    input  logic [7:0]       i_max_len,
    output ssx_pkg::t_push   o_push
);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_FORMATTED,
        PH_STRINGS
    } t_phase;

    t_phase     r_phase,   n_phase;
    logic [7:0] r_offset,  n_offset;
    logic [7:0] r_length,  n_length;
    logic [7:0] r_type,    n_type;
    logic [7:0] r_wanted,  n_wanted;
    logic [7:0] r_strnum,  n_strnum;
    logic       r_prevz,   n_prevz;
    logic [7:0] r_emitted, n_emitted;
    logic       r_done,    n_done;

    ssx_pkg::t_result w_char;
    ssx_pkg::t_result w_fend;
    ssx_pkg::t_result w_nend;

    always_comb begin
        w_char = '{out_byte: i_data_byte, is_end: 1'b0, found: 1'b0};
        w_fend = '{out_byte: 8'h00, is_end: 1'b1, found: 1'b1};
        w_nend = '{out_byte: 8'h00, is_end: 1'b1, found: 1'b0};

        n_phase   = r_phase;
        n_offset  = r_offset;
        n_length  = r_length;
        n_type    = r_type;
        n_wanted  = r_wanted;
        n_strnum  = r_strnum;
        n_prevz   = r_prevz;
        n_emitted = r_emitted;
        n_done    = r_done;
        o_push    = '0;

        if (i_valid && !r_done) begin
            case (r_phase)
                PH_TYPE: begin
                    n_type   = i_data_byte;
                    n_wanted = 8'h00;
                    n_offset = 8'h01;
                    n_phase  = PH_LEN;
                end
                PH_LEN: begin
                    n_length = (i_data_byte < ssx_pkg::MIN_LEN) ? ssx_pkg::MIN_LEN
                                                                 : i_data_byte;
                    n_offset = 8'h02;
                    n_phase  = PH_FORMATTED;
                end
                PH_FORMATTED: begin
                    if (r_offset == ssx_pkg::SERIAL_OFFSET && r_type == ssx_pkg::SERIAL_TYPE
                        && r_length >= ssx_pkg::SERIAL_MIN_LEN) begin
                        n_wanted = i_data_byte;
                    end
                    n_offset = r_offset + 8'h01;
                    if (n_offset >= r_length) begin
                        n_phase  = PH_STRINGS;
                        n_offset = 8'h00;
                        n_strnum = 8'h01;
                        n_prevz  = 1'b0;
                    end
                end
                default: begin
                    if (i_data_byte == 8'h00) begin
                        if (r_prevz) begin
                            // Double null closes the structure.
                            n_phase  = PH_TYPE;
                            n_offset = 8'h00;
                            n_prevz  = 1'b0;
                        end else if (r_strnum == r_wanted && r_offset != 8'h00) begin
                            o_push.cnt  = 2'd1;
                            o_push.res0 = w_fend;
                            n_done      = 1'b1;
                        end else begin
                            if (r_strnum != ssx_pkg::MAX_COUNT) begin
                                n_strnum = r_strnum + 8'h01;
                            end
                            n_offset = 8'h00;
                            n_prevz  = 1'b1;
                        end
                    end else begin
                        n_prevz = 1'b0;
                        if (r_strnum == r_wanted && r_emitted < i_max_len) begin
                            o_push.cnt  = 2'd1;
                            o_push.res0 = w_char;
                            n_emitted   = r_emitted + 8'h01;
                        end
                        if (r_offset != ssx_pkg::MAX_COUNT) begin
                            n_offset = r_offset + 8'h01;
                        end
                    end
                end
            endcase
        end

        if (i_valid && i_last_of_table) begin
            if (!n_done) begin
                if (o_push.cnt == 2'd0) begin
                    o_push.res0 = w_nend;
                end else begin
                    o_push.res1 = w_nend;
                end
                o_push.cnt = o_push.cnt + 2'd1;
            end
            n_phase   = PH_TYPE;
            n_offset  = 8'h00;
            n_length  = 8'h00;
            n_type    = 8'h00;
            n_wanted  = 8'h00;
            n_strnum  = 8'h01;
            n_prevz   = 1'b0;
            n_emitted = 8'h00;
            n_done    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TYPE;
            r_offset  <= 8'h00;
            r_length  <= 8'h00;
            r_type    <= 8'h00;
            r_wanted  <= 8'h00;
            r_strnum  <= 8'h01;
            r_prevz   <= 1'b0;
            r_emitted <= 8'h00;
            r_done    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_offset  <= n_offset;
            r_length  <= n_length;
            r_type    <= n_type;
            r_wanted  <= n_wanted;
            r_strnum  <= n_strnum;
            r_prevz   <= n_prevz;
            r_emitted <= n_emitted;
            r_done    <= n_done;
        end
    end

endmodule

@@ rtl/core/ssx_fifo.sv @@
module ssx_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ssx_pkg::t_push               i_push,
    input  logic                         i_pop,
    output ssx_pkg::t_result             o_head,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    ssx_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic [AW-1:0]    w_wr_ptr1;

    assign w_wr_ptr1 = r_wr_ptr + AW'(1);
    assign o_head    = r_mem[r_rd_ptr];
    assign o_count   = r_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr + AW'(i_push.cnt);
        n_rd_ptr = r_rd_ptr + AW'(i_pop);
        n_count  = r_count + CW'(i_push.cnt) - CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[w_wr_ptr1] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/core/smbios_serial_string_extractor_unit.sv @@
// Path: a byte is registered at acceptance and its results are written to the output
// queue in the cycle after that, from where each result beat is offered to the consumer.
// Throughput: one byte per cycle; each byte yields at most two result beats, and the output
// side drains one beat per cycle, so input stalls only when the output queue backs up.
// Reset: synchronous and active low; the parser rearms, the queue empties, and
// max_serial_length returns to 255.
module smbios_serial_string_extractor_unit #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Byte stream of the structure table.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_of_table,
    // Serial characters and end marker.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_is_end,
    output logic        o_found,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The queue depth must be a power of two of at least four so that the
    // pointers wrap naturally and two in-flight bytes can always be absorbed.
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int RW = CW + 1;

    // Configuration register. Only register 0 exists; the upper address bit
    // selects a register index beyond the list, which is ignored.
    logic [7:0] r_max_len;
    logic       w_cfg_write;

    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready
                         && (paddr[2] == ssx_pkg::REG_MAX_SERIAL_LENGTH);
    assign prdata      = (paddr[2] == ssx_pkg::REG_MAX_SERIAL_LENGTH) ? {24'h0, r_max_len}
                                                                     : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= ssx_pkg::MAX_LEN_RESET;
        end else if (w_cfg_write) begin
            r_max_len <= pwdata[7:0];
        end
    end

    // Input register. Every registered byte is parsed in the following cycle
    // without condition; the ready logic below guarantees the queue has room.
    logic       r_in_valid;
    logic [7:0] r_data_byte;
    logic       r_last;
    logic       w_in_accept;

    assign w_in_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_data_byte <= i_data_byte;
            r_last      <= i_last_of_table;
        end
    end

    // Parser: one pass of the structure walker per registered byte.
    ssx_pkg::t_push w_push;

    ssx_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_in_valid),
        .i_data_byte     (r_data_byte),
        .i_last_of_table (r_last),
        .i_max_len       (r_max_len),
        .o_push          (w_push)
    );

    // Output queue. It decouples the parser from the consumer so bytes keep
    // flowing while a result beat waits to be taken.
    ssx_pkg::t_result w_head;
    logic [CW-1:0]    w_count;
    logic             w_pop;
    logic [RW-1:0]    w_reserved;

    assign o_out_valid = (w_count != '0);
    assign w_pop       = o_out_valid && i_out_ready;
    assign o_out_byte  = w_head.out_byte;
    assign o_is_end    = w_head.is_end;
    assign o_found     = w_head.found;

    ssx_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_count (w_count)
    );

    // A new byte is taken only if the queue can hold the worst case of two
    // beats for the byte now in the parser and two for the new one.
    assign w_reserved = RW'(w_count) + (r_in_valid ? RW'(2) : RW'(0));
    assign o_in_ready = (w_reserved <= RW'(FIFO_DEPTH - 2));

`ifndef NO_ASSERTIONS
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        RW'(w_count) <= RW'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_idle_no_push : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> (w_push.cnt == 2'd0))
        else $error("parser produced results without a registered byte");

    a_push_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt == 2'd2) |-> (r_last && w_push.res1.is_end && !w_push.res1.found))
        else $error("second result beat is not a table end marker");

    a_accept_registers : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_in_valid)
        else $error("accepted byte did not reach the input register");
`endif

endmodule
